[hdl/etc1_block_decoder_unit_macros.svh]
// assertion macros for the etc1 block decoder
// expects clk_i and rst_ni in the including scope
`ifndef ETC1_BLOCK_DECODER_UNIT_MACROS_SVH
`define ETC1_BLOCK_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define ETC1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETC1_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/etc1_pkg.sv]
// shared types, constants and helper functions for the etc1 block decoder
// no dependencies
package etc1_pkg;

  localparam int unsigned ChanW         = 8;
  localparam int unsigned TexelCnt      = 16;
  localparam int unsigned TexelIdxW     = $clog2(TexelCnt);
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned TabW          = 3;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef struct packed {
    rgb_t            col0;
    rgb_t            col1;
    logic [TabW-1:0] tab0;
    logic [TabW-1:0] tab1;
    logic            flip;
    logic [31:0]     idx_bits;
  } blk_t;

  // modifier lookup: idx[0] picks the large value, idx[1] negates it
  function automatic logic signed [8:0] mod_val(input logic [TabW-1:0] tab,
                                                input logic [1:0] idx);
    logic [7:0] small_mag;
    logic [7:0] large_mag;
    logic [8:0] mag;
    case (tab)
      3'd0: begin small_mag = 8'd2;  large_mag = 8'd8;   end
      3'd1: begin small_mag = 8'd5;  large_mag = 8'd17;  end
      3'd2: begin small_mag = 8'd9;  large_mag = 8'd29;  end
      3'd3: begin small_mag = 8'd13; large_mag = 8'd42;  end
      3'd4: begin small_mag = 8'd18; large_mag = 8'd60;  end
      3'd5: begin small_mag = 8'd24; large_mag = 8'd80;  end
      3'd6: begin small_mag = 8'd33; large_mag = 8'd106; end
      3'd7: begin small_mag = 8'd47; large_mag = 8'd183; end
      default: begin small_mag = 8'd0; large_mag = 8'd0; end
    endcase
    mag = {1'b0, (idx[0] ? large_mag : small_mag)};
    return idx[1] ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic chan_t clamp8(input logic signed [9:0] v);
    if (v < 10'sd0) begin
      return '0;
    end else if (v > 10'sd255) begin
      return chan_t'(8'd255);
    end
    return v[ChanW-1:0];
  endfunction

endpackage

[hdl/etc1_block_decoder_unit.sv]
// ETC1 4x4 block decoder, one texel per cycle out.
// A block is taken at a rising edge with start high and busy low, as
// word_high_i / word_low_i (the block's big-endian words).
// cfg_we_i / cfg_wdata_i write the channel-order bit (1 = blue first);
// write it only while no block is in flight.
// Each block gives sixteen texels, one per cycle on consecutive cycles, each
// marked by texel_strobe_o for one cycle; final_texel_o flags the last.
// The receiver cannot stall: every strobed texel is a transfer.
// A block passes the front decode register, the block queue, the sequencer's
// block register and the output register before its first texel shows.
// Block throughput is set by the back-end texel sequencer, which emits one
// texel a cycle and takes the next block as it works on the last texel of
// the current one. The front decode register and the block queue take
// further blocks meanwhile; busy rises only when both are full.
// Reset clears the queue, sequencer and channel-order bit; no block is in
// flight afterwards.
// depends on etc1_pkg, etc1_front, etc1_queue, etc1_back and the macro header
module etc1_block_decoder_unit #(
  parameter int unsigned QueueDepth = etc1_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] word_high_i,
  input  logic [31:0] word_low_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        texel_strobe_o,
  output logic [1:0]  texel_col_o,
  output logic [1:0]  texel_row_o,
  output logic [7:0]  chan_first_o,
  output logic [7:0]  chan_middle_o,
  output logic [7:0]  chan_final_o,
  output logic        final_texel_o
);
  import etc1_pkg::*;

`include "etc1_block_decoder_unit_macros.svh"

  logic bgr_q, bgr_d;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  blk_t push_data, pop_data;

  assign bgr_d = cfg_we_i ? cfg_wdata_i : bgr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bgr_q <= 1'b0;
    end else begin
      bgr_q <= bgr_d;
    end
  end

  etc1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .word_high_i  (word_high_i),
    .word_low_i   (word_low_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  etc1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  etc1_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .bgr_order_i    (bgr_q),
    .texel_strobe_o (texel_strobe_o),
    .texel_col_o    (texel_col_o),
    .texel_row_o    (texel_row_o),
    .chan_first_o   (chan_first_o),
    .chan_middle_o  (chan_middle_o),
    .chan_final_o   (chan_final_o),
    .final_texel_o  (final_texel_o)
  );

  `ETC1_ASSERT_NOW(a_final_has_strobe, final_texel_o, texel_strobe_o, "final flag without strobe")
  `ETC1_ASSERT_NXT(a_texels_contiguous, texel_strobe_o && !final_texel_o, texel_strobe_o, "gap inside a block")
  `ETC1_ASSERT_NOW(a_busy_means_stuck, busy, push_valid && !push_ready, "busy while queue can take")

endmodule

[hdl/etc1_front.sv]
// front stage: takes a compressed block, decodes base colours and tables
// depends on etc1_pkg
module etc1_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        word_high_i,
  input  logic [31:0]        word_low_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output etc1_pkg::blk_t     push_data_o
);
  import etc1_pkg::*;

  function automatic chan_t expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic chan_t expand4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [4:0] add_delta(input logic [4:0] base, input logic [2:0] d);
    return base + {{2{d[2]}}, d};
  endfunction

  logic  valid_q, valid_d;
  blk_t  data_q, data_d;
  blk_t  dec;
  logic  accept;

  always_comb begin
    dec.tab0     = word_high_i[7:5];
    dec.tab1     = word_high_i[4:2];
    dec.flip     = word_high_i[0];
    dec.idx_bits = word_low_i;
    if (word_high_i[1]) begin
      dec.col0.r = expand5(word_high_i[31:27]);
      dec.col0.g = expand5(word_high_i[23:19]);
      dec.col0.b = expand5(word_high_i[15:11]);
      dec.col1.r = expand5(add_delta(word_high_i[31:27], word_high_i[26:24]));
      dec.col1.g = expand5(add_delta(word_high_i[23:19], word_high_i[18:16]));
      dec.col1.b = expand5(add_delta(word_high_i[15:11], word_high_i[10:8]));
    end else begin
      dec.col0.r = expand4(word_high_i[31:28]);
      dec.col0.g = expand4(word_high_i[23:20]);
      dec.col0.b = expand4(word_high_i[15:12]);
      dec.col1.r = expand4(word_high_i[27:24]);
      dec.col1.g = expand4(word_high_i[19:16]);
      dec.col1.b = expand4(word_high_i[11:8]);
    end
  end

  assign busy   = valid_q && !push_ready_i;
  assign accept = start && !busy;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (accept) begin
      valid_d = 1'b1;
      data_d  = dec;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = data_q;

endmodule

[hdl/etc1_queue.sv]
// short block queue between the front and back stages
// depends on etc1_pkg
module etc1_queue #(
  parameter int unsigned Depth = etc1_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  etc1_pkg::blk_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output etc1_pkg::blk_t pop_data_o
);
  import etc1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/etc1_back.sv]
// back stage: walks the sixteen texels of a decoded block, one per cycle
// depends on etc1_pkg
module etc1_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  etc1_pkg::blk_t pop_data_i,
  input  logic           bgr_order_i,
  output logic           texel_strobe_o,
  output logic [1:0]     texel_col_o,
  output logic [1:0]     texel_row_o,
  output logic [7:0]     chan_first_o,
  output logic [7:0]     chan_middle_o,
  output logic [7:0]     chan_final_o,
  output logic           final_texel_o
);
  import etc1_pkg::*;

  localparam logic [TexelIdxW-1:0] LastCnt = TexelIdxW'(TexelCnt - 1);

  logic                 active_q, active_d;
  logic [TexelIdxW-1:0] cnt_q, cnt_d;
  blk_t                 blk_q, blk_d;
  logic                 pop;

  logic                 sub;
  logic [2:0]           pos;
  logic [1:0]           x, y;
  logic [3:0]           k;
  logic [1:0]           idx;
  logic [TabW-1:0]      tab;
  rgb_t                 base;
  logic signed [8:0]    m;
  chan_t                ch_r, ch_g, ch_b;

  logic                 strobe_q, strobe_d;
  logic [1:0]           col_q, col_d, row_q, row_d;
  chan_t                first_q, first_d, middle_q, middle_d, last_q, last_d;
  logic                 fin_q, fin_d;

  assign pop_ready_o = !active_q || (cnt_q == LastCnt);
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q + TexelIdxW'(1);
    blk_d    = blk_q;
    if (pop) begin
      active_d = 1'b1;
      cnt_d    = '0;
      blk_d    = pop_data_i;
    end else if (pop_ready_o) begin
      active_d = 1'b0;
      cnt_d    = '0;
    end
  end

  // texel position and colour for the current count
  always_comb begin
    sub = cnt_q[3];
    pos = cnt_q[2:0];
    if (blk_q.flip) begin
      x = pos[2:1];
      y = {sub, pos[0]};
    end else begin
      x = {sub, pos[2]};
      y = pos[1:0];
    end
    k    = {x, y};
    idx  = {blk_q.idx_bits[5'd16 + {1'b0, k}], blk_q.idx_bits[{1'b0, k}]};
    tab  = sub ? blk_q.tab1 : blk_q.tab0;
    base = sub ? blk_q.col1 : blk_q.col0;
    m    = mod_val(tab, idx);
    ch_r = clamp8($signed({2'b00, base.r}) + $signed({m[8], m}));
    ch_g = clamp8($signed({2'b00, base.g}) + $signed({m[8], m}));
    ch_b = clamp8($signed({2'b00, base.b}) + $signed({m[8], m}));
  end

  always_comb begin
    strobe_d = active_q;
    col_d    = x;
    row_d    = y;
    first_d  = bgr_order_i ? ch_b : ch_r;
    middle_d = ch_g;
    last_d   = bgr_order_i ? ch_r : ch_b;
    fin_d    = active_q && (cnt_q == LastCnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    col_q    <= col_d;
    row_q    <= row_d;
    first_q  <= first_d;
    middle_q <= middle_d;
    last_q   <= last_d;
  end

  assign texel_strobe_o = strobe_q;
  assign texel_col_o    = col_q;
  assign texel_row_o    = row_q;
  assign chan_first_o   = first_q;
  assign chan_middle_o  = middle_q;
  assign chan_final_o   = last_q;
  assign final_texel_o  = fin_q;

endmodule

[sim/tb_etc1_block_decoder_unit.sv]
// self-checking testbench for etc1_block_decoder_unit: directed blocks, then random
// blocks under several idle patterns, each texel checked against a local block decoder
// depends on hdl/etc1_block_decoder_unit.sv and etc1_pkg
`timescale 1ns / 100ps

module tb_etc1_block_decoder_unit;

  typedef struct {
    logic [1:0] col;
    logic [1:0] row;
    logic [7:0] c_first;
    logic [7:0] c_middle;
    logic [7:0] c_final;
    logic       last;
  } texel_t;

  typedef struct {
    logic [31:0] hi;
    logic [31:0] lo;
    logic        fixed;
    logic [7:0]  fixed_val;
  } blk_row_t;

  localparam int DirRows = 21;
  localparam int PipeWait = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] word_high_i;
  logic [31:0] word_low_i;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        texel_strobe_o;
  logic [1:0]  texel_col_o;
  logic [1:0]  texel_row_o;
  logic [7:0]  chan_first_o;
  logic [7:0]  chan_middle_o;
  logic [7:0]  chan_final_o;
  logic        final_texel_o;

  texel_t   texel_q[$];
  blk_row_t dir_tab[DirRows];
  logic     bgr_sel;
  int       mismatch_cnt;

  etc1_block_decoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .word_high_i    (word_high_i),
    .word_low_i     (word_low_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .texel_strobe_o (texel_strobe_o),
    .texel_col_o    (texel_col_o),
    .texel_row_o    (texel_row_o),
    .chan_first_o   (chan_first_o),
    .chan_middle_o  (chan_middle_o),
    .chan_final_o   (chan_final_o),
    .final_texel_o  (final_texel_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // decodes one block and queues its sixteen texels in emission order
  task automatic decode_block(input logic [31:0] hi, input logic [31:0] lo,
                              input logic bgr);
    int         base_col [2][3];
    int         tab [2];
    int         s, i, c, x, y, k, m, mag;
    int         base5;
    int         ch [3];
    logic [2:0] dlt;
    logic [1:0] idx;
    logic       flip;
    texel_t     t;
    flip = hi[0];
    for (c = 0; c < 3; c++) begin
      if (hi[1]) begin
        base5 = int'((hi >> (27 - 8 * c)) & 32'd31);
        dlt = 3'((hi >> (24 - 8 * c)) & 32'd7);
        base_col[0][c] = (base5 << 3) | (base5 >> 2);
        base5 = (base5 + int'($signed(dlt)) + 32) & 31;
        base_col[1][c] = (base5 << 3) | (base5 >> 2);
      end else begin
        base_col[0][c] = int'((hi >> (28 - 8 * c)) & 32'd15) * 17;
        base_col[1][c] = int'((hi >> (24 - 8 * c)) & 32'd15) * 17;
      end
    end
    tab[0] = int'(hi[7:5]);
    tab[1] = int'(hi[4:2]);
    for (s = 0; s < 2; s++) begin
      for (i = 0; i < 8; i++) begin
        if (flip) begin
          x = i >> 1;
          y = (s ? 2 : 0) + (i & 1);
        end else begin
          x = (s ? 2 : 0) + (i >> 2);
          y = i & 3;
        end
        k = y + 4 * x;
        idx = {lo[k + 16], lo[k]};
        case (tab[s])
          0: mag = idx[0] ? 8 : 2;
          1: mag = idx[0] ? 17 : 5;
          2: mag = idx[0] ? 29 : 9;
          3: mag = idx[0] ? 42 : 13;
          4: mag = idx[0] ? 60 : 18;
          5: mag = idx[0] ? 80 : 24;
          6: mag = idx[0] ? 106 : 33;
          default: mag = idx[0] ? 183 : 47;
        endcase
        m = idx[1] ? -mag : mag;
        for (c = 0; c < 3; c++) begin
          ch[c] = base_col[s][c] + m;
          if (ch[c] < 0) ch[c] = 0;
          if (ch[c] > 255) ch[c] = 255;
        end
        t.col = 2'(x);
        t.row = 2'(y);
        t.c_first = 8'(bgr ? ch[2] : ch[0]);
        t.c_middle = 8'(ch[1]);
        t.c_final = 8'(bgr ? ch[0] : ch[2]);
        t.last = (s == 1) && (i == 7);
        texel_q.push_back(t);
      end
    end
  endtask

  // one block transfer, after a random number of idle cycles
  task automatic send_block(input blk_row_t blk, input int idle_pct);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      word_high_i <= $urandom;
      word_low_i <= $urandom;
      @(posedge clk_i);
    end
    start <= 1'b1;
    word_high_i <= blk.hi;
    word_low_i <= blk.lo;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    decode_block(blk.hi, blk.lo, bgr_sel);
    if (blk.fixed) begin
      n = texel_q.size();
      for (int j = n - 16; j < n; j++) begin
        texel_q[j].c_first = blk.fixed_val;
        texel_q[j].c_middle = blk.fixed_val;
        texel_q[j].c_final = blk.fixed_val;
      end
    end
  endtask

  task automatic write_order(input logic val);
    start <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk_i);
    repeat (PipeWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bgr_sel = val;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $realtime, name, exp_v,
               act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    texel_t t;
    if (rst_ni && texel_strobe_o) begin
      if (texel_q.size() == 0) begin
        $display("%0t: unexpected texel, expected none, actual col %0d row %0d",
                 $realtime, texel_col_o, texel_row_o);
        mismatch_cnt++;
      end else begin
        t = texel_q.pop_front();
        check_field("texel_col", t.col, texel_col_o);
        check_field("texel_row", t.row, texel_row_o);
        check_field("chan_first", t.c_first, chan_first_o);
        check_field("chan_middle", t.c_middle, chan_middle_o);
        check_field("chan_final", t.c_final, chan_final_o);
        check_field("final_texel", t.last, final_texel_o);
      end
    end
  end

  initial begin
    blk_row_t blk;
    int       idle_pct;
    rst_ni = 1'b0;
    start = 1'b0;
    word_high_i = '0;
    word_low_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    bgr_sel = 1'b0;
    mismatch_cnt = 0;

    // uniform blocks with known colors, mode and wrap corners, every table code
    dir_tab[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1, 8'd2};
    dir_tab[1]  = '{32'h0000_0000, 32'hFFFF_0000, 1'b1, 8'd0};
    dir_tab[2]  = '{32'hFFFF_FFFC, 32'h0000_FFFF, 1'b1, 8'd255};
    dir_tab[3]  = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 8'd72};
    dir_tab[4]  = '{32'h0000_0002, 32'h0000_0000, 1'b1, 8'd2};
    dir_tab[5]  = '{32'h0000_0003, 32'h0000_0000, 1'b1, 8'd2};
    dir_tab[6]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'd0};
    dir_tab[7]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'd0};
    dir_tab[8]  = '{32'hFBFB_FB02, 32'h1234_5678, 1'b0, 8'd0};
    dir_tab[9]  = '{32'h0404_0403, 32'h9ABC_DEF0, 1'b0, 8'd0};
    dir_tab[10] = '{32'h0000_0001, 32'hAAAA_5555, 1'b0, 8'd0};
    dir_tab[11] = '{32'h1234_5678, 32'h8765_4321, 1'b0, 8'd0};
    dir_tab[12] = '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 8'd0};
    for (int k = 0; k < 8; k++) begin
      dir_tab[13 + k] = '{32'h8888_8800 | (k << 5) | ((7 - k) << 2) | (k & 1),
                          32'h3C5A_C3A5, 1'b0, 8'd0};
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset channel order first
    for (int r = 0; r < DirRows; r++) send_block(dir_tab[r], 0);

    for (int ph = 0; ph < 4; ph++) begin
      write_order(ph[0] ? 1'b0 : 1'b1);
      case (ph)
        1: idle_pct = 76;
        3: idle_pct = 13;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 28; n++) begin
        blk.hi = $urandom;
        blk.lo = $urandom;
        blk.fixed = 1'b0;
        blk.fixed_val = '0;
        // push colors toward the clamp limits now and then
        if ($urandom_range(3) == 0) blk.hi[31:8] = {24{blk.hi[8]}};
        send_block(blk, idle_pct);
      end
    end
    write_order(1'b0);
    send_block(dir_tab[12], 0);

    start <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk_i);
    repeat (PipeWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("Verification failed");
    $finish;
  end

endmodule
